// ----- src/lavm_pkg.sv -----
// Shared constants, types and helpers for the look-at view matrix unit.
package lavm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int DIFF_W        = DATA_W + 1;
  localparam int MAG_W         = 31;
  localparam int ROOT_W        = 32;

  localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ROW_S = 2'd0,
    ROW_U = 2'd1,
    ROW_F = 2'd2,
    ROW_H = 2'd3
  } row_t;

  function automatic int norm_lat(input int frac);
    return 4 + ROOT_W + 1 + frac + 1;
  endfunction

endpackage

// ----- src/lavm_if.sv -----
// Request and row channel interfaces of the look-at view matrix unit.
interface lavm_req_if;
  logic                             valid;
  logic                             ready;
  logic signed [lavm_pkg::DATA_W-1:0] eye_x;
  logic signed [lavm_pkg::DATA_W-1:0] eye_y;
  logic signed [lavm_pkg::DATA_W-1:0] eye_z;
  logic signed [lavm_pkg::DATA_W-1:0] target_x;
  logic signed [lavm_pkg::DATA_W-1:0] target_y;
  logic signed [lavm_pkg::DATA_W-1:0] target_z;
  logic signed [lavm_pkg::DATA_W-1:0] up_x;
  logic signed [lavm_pkg::DATA_W-1:0] up_y;
  logic signed [lavm_pkg::DATA_W-1:0] up_z;

  modport source (
    output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
    input  ready
  );
  modport sink (
    input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
    output ready
  );
endinterface

interface lavm_row_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         row_index;
  logic signed [lavm_pkg::DATA_W-1:0] col0;
  logic signed [lavm_pkg::DATA_W-1:0] col1;
  logic signed [lavm_pkg::DATA_W-1:0] col2;
  logic signed [lavm_pkg::DATA_W-1:0] col3;
  logic                               degenerate;
  logic                               last_row;

  modport source (
    output valid, row_index, col0, col1, col2, col3, degenerate, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_index, col0, col1, col2, col3, degenerate, last_row,
    output ready
  );
endinterface

// ----- src/lavm_delay.sv -----
// Stallable delay line that carries a valid bit and side data alongside the datapath.
module lavm_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic [DEPTH-1:0] vld;
  logic [W-1:0]     dat [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < DEPTH; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dat[0] <= in_data;
      for (int k = 1; k < DEPTH; k++) begin
        dat[k] <= dat[k-1];
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = dat[DEPTH-1];

endmodule

// ----- src/lavm_norm.sv -----
// Pipelined vector normalizer: prescale, sum of squares, square root, per-lane division.
module lavm_norm #(
  parameter int IW        = 33,
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [2:0][IW-1:0]        vec,
  output logic [2:0][FRAC_BITS+1:0] unit,
  output logic                      deg
);

  localparam int MW  = lavm_pkg::MAG_W;
  localparam int RW  = lavm_pkg::ROOT_W;
  localparam int UW  = FRAC_BITS + 2;
  localparam int QW  = FRAC_BITS + 1;
  localparam int EW  = (IW > MW) ? IW : MW;
  localparam int SHW = $clog2(EW);
  localparam int SQW = 2 * RW;
  localparam int SRW = RW + 4;
  localparam int NW  = MW + FRAC_BITS + 1;
  localparam int DRW = RW + 1;

  // magnitude and sign
  logic [2:0][IW-1:0] mag_c;
  logic [2:0][EW-1:0] a_mag;
  logic [2:0]         a_neg;
  logic               a_zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec[i][IW-1] ? (~vec[i] + 1'b1) : vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= vec[i][IW-1];
        a_mag[i] <= EW'(mag_c[i]);
      end
      a_zero <= (vec == '0);
    end
  end

  // prescale below 2^31
  logic [EW-1:0]          or_all;
  logic [SHW-1:0]         msb;
  logic [SHW-1:0]         shamt;
  logic [2:0][EW-1:0]     shifted;
  logic [2:0][MW-1:0]     b_m;
  logic [2:0]             b_neg;
  logic                   b_zero;

  always_comb begin
    or_all = a_mag[0] | a_mag[1] | a_mag[2];
    msb    = '0;
    for (int k = 0; k < EW; k++) begin
      if (or_all[k]) begin
        msb = SHW'(k);
      end
    end
    shamt = (msb >= SHW'(MW)) ? (msb - SHW'(MW - 1)) : '0;
    for (int i = 0; i < 3; i++) begin
      shifted[i] = a_mag[i] >> shamt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_m[i] <= shifted[i][MW-1:0];
      end
      b_neg  <= a_neg;
      b_zero <= a_zero;
    end
  end

  // squares
  logic [2:0][2*MW-1:0] c_sq;
  logic [2:0][MW-1:0]   c_m;
  logic [2:0]           c_neg;
  logic                 c_zero;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c_sq[i] <= b_m[i] * b_m[i];
      end
      c_m    <= b_m;
      c_neg  <= b_neg;
      c_zero <= b_zero;
    end
  end

  // square root, one result bit per stage
  logic [SQW-1:0]     q_sum  [RW+1];
  logic [SRW-1:0]     q_rem  [RW+1];
  logic [RW-1:0]      q_root [RW+1];
  logic [2:0][MW-1:0] q_m    [RW+1];
  logic [2:0]         q_neg  [RW+1];
  logic               q_zero [RW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      q_sum[0]  <= SQW'(c_sq[0]) + SQW'(c_sq[1]) + SQW'(c_sq[2]);
      q_rem[0]  <= '0;
      q_root[0] <= '0;
      q_m[0]    <= c_m;
      q_neg[0]  <= c_neg;
      q_zero[0] <= c_zero;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [SRW-1:0] cur;
    logic [SRW-1:0] trial;

    always_comb begin
      cur   = {q_rem[k][SRW-3:0], q_sum[k][2*(RW-1-k)+1 -: 2]};
      trial = SRW'({q_root[k], 2'b01});
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (cur >= trial) begin
          q_rem[k+1]  <= cur - trial;
          q_root[k+1] <= {q_root[k][RW-2:0], 1'b1};
        end else begin
          q_rem[k+1]  <= cur;
          q_root[k+1] <= {q_root[k][RW-2:0], 1'b0};
        end
        q_sum[k+1]  <= q_sum[k];
        q_m[k+1]    <= q_m[k];
        q_neg[k+1]  <= q_neg[k];
        q_zero[k+1] <= q_zero[k];
      end
    end
  end

  // rounded division by the length, one quotient bit per stage
  logic [2:0][NW-1:0]  p_num  [QW+1];
  logic [2:0][DRW-1:0] p_rem  [QW+1];
  logic [2:0][QW-1:0]  p_q    [QW+1];
  logic [RW-1:0]       p_len  [QW+1];
  logic [2:0]          p_neg  [QW+1];
  logic                p_zero [QW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p_num[0][i] <= NW'({q_m[RW][i], FRAC_BITS'(0)}) + NW'(q_root[RW][RW-1:1]);
      end
      p_rem[0]  <= '0;
      p_q[0]    <= '0;
      p_len[0]  <= q_root[RW];
      p_neg[0]  <= q_neg[RW];
      p_zero[0] <= q_zero[RW];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][DRW-1:0] rin;
    logic [2:0][DRW-1:0] cur;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rin[i] = (j == 0) ? DRW'(p_num[j][i][NW-1:QW]) : p_rem[j][i];
        cur[i] = {rin[i][DRW-2:0], p_num[j][i][QW-1-j]};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          if (cur[i] >= DRW'(p_len[j])) begin
            p_rem[j+1][i] <= cur[i] - DRW'(p_len[j]);
            p_q[j+1][i]   <= {p_q[j][i][QW-2:0], 1'b1};
          end else begin
            p_rem[j+1][i] <= cur[i];
            p_q[j+1][i]   <= {p_q[j][i][QW-2:0], 1'b0};
          end
        end
        p_num[j+1]  <= p_num[j];
        p_len[j+1]  <= p_len[j];
        p_neg[j+1]  <= p_neg[j];
        p_zero[j+1] <= p_zero[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p_zero[QW]) begin
        unit[i] = '0;
      end else if (p_neg[QW][i]) begin
        unit[i] = ~UW'(p_q[QW][i]) + 1'b1;
      end else begin
        unit[i] = UW'(p_q[QW][i]);
      end
    end
  end

  assign deg = p_zero[QW];

endmodule

// ----- src/lavm_cross.sv -----
// Two-stage cross product of unit vectors at full precision.
module lavm_cross #(
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              adv,
  input  logic [2:0][FRAC_BITS+1:0]         a,
  input  logic [2:0][FRAC_BITS+1:0]         b,
  output logic [2:0][2*(FRAC_BITS+2):0]     c
);

  localparam int UW = FRAC_BITS + 2;
  localparam int PW = 2 * UW;

  logic [5:0][PW-1:0] pr;

  always_ff @(posedge clk) begin
    if (adv) begin
      pr[0] <= $signed(a[1]) * $signed(b[2]);
      pr[1] <= $signed(a[2]) * $signed(b[1]);
      pr[2] <= $signed(a[2]) * $signed(b[0]);
      pr[3] <= $signed(a[0]) * $signed(b[2]);
      pr[4] <= $signed(a[0]) * $signed(b[1]);
      pr[5] <= $signed(a[1]) * $signed(b[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c[0] <= {pr[0][PW-1], pr[0]} - {pr[1][PW-1], pr[1]};
      c[1] <= {pr[2][PW-1], pr[2]} - {pr[3][PW-1], pr[3]};
      c[2] <= {pr[4][PW-1], pr[4]} - {pr[5][PW-1], pr[5]};
    end
  end

endmodule

// ----- src/lavm_rowout.sv -----
// Translation dot products, rounding and saturation, and the four-beat row serializer.
module lavm_rowout #(
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [2:0][lavm_pkg::DATA_W-1:0]      eye,
  input  logic [2:0][FRAC_BITS+1:0]             s,
  input  logic [2:0][FRAC_BITS+1:0]             u,
  input  logic [2:0][FRAC_BITS+1:0]             f,
  input  logic                                  deg,
  output logic                                  adv,
  lavm_row_if.source                            row
);

  localparam int DW  = lavm_pkg::DATA_W;
  localparam int UW  = FRAC_BITS + 2;
  localparam int PW  = UW + DW;
  localparam int SW  = PW + 2;
  localparam logic [2:0] NEG_ROW = 3'b011;

  // products
  logic                          r1_v;
  logic [2:0][2:0][PW-1:0]       r1_pr;
  logic [2:0][UW-1:0]            r1_s, r1_u, r1_f;
  logic                          r1_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
    end else if (adv) begin
      r1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        r1_pr[0][i] <= $signed(s[i]) * $signed(eye[i]);
        r1_pr[1][i] <= $signed(u[i]) * $signed(eye[i]);
        r1_pr[2][i] <= $signed(f[i]) * $signed(eye[i]);
      end
      r1_s   <= s;
      r1_u   <= u;
      r1_f   <= f;
      r1_deg <= deg;
    end
  end

  // sums
  logic                   r2_v;
  logic [2:0][SW-1:0]     r2_d;
  logic [2:0][UW-1:0]     r2_s, r2_u, r2_f;
  logic                   r2_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_v <= 1'b0;
    end else if (adv) begin
      r2_v <= r1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        r2_d[r] <= {{2{r1_pr[r][0][PW-1]}}, r1_pr[r][0]}
                 + {{2{r1_pr[r][1][PW-1]}}, r1_pr[r][1]}
                 + {{2{r1_pr[r][2][PW-1]}}, r1_pr[r][2]};
      end
      r2_s   <= r1_s;
      r2_u   <= r1_u;
      r2_f   <= r1_f;
      r2_deg <= r1_deg;
    end
  end

  // round half away from zero, negate, saturate
  logic [2:0][SW-1:0] dmag;
  logic [2:0][SW-1:0] rm;
  logic [2:0]         rneg;
  logic [2:0][DW-1:0] tr;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dmag[r] = r2_d[r][SW-1] ? (~r2_d[r] + 1'b1) : r2_d[r];
      rm[r]   = (dmag[r] + (SW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      rneg[r] = r2_d[r][SW-1] ^ NEG_ROW[r];
      if (rm[r] >= (SW'(1) << (DW - 1))) begin
        tr[r] = rneg[r] ? lavm_pkg::DATA_MIN : lavm_pkg::DATA_MAX;
      end else if (rneg[r]) begin
        tr[r] = ~rm[r][DW-1:0] + 1'b1;
      end else begin
        tr[r] = rm[r][DW-1:0];
      end
    end
  end

  logic                   r3_v;
  logic [2:0][DW-1:0]     r3_t;
  logic [2:0][UW-1:0]     r3_s, r3_u, r3_f;
  logic                   r3_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_v <= 1'b0;
    end else if (adv) begin
      r3_v <= r2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r3_t   <= tr;
      r3_s   <= r2_s;
      r3_u   <= r2_u;
      r3_f   <= r2_f;
      r3_deg <= r2_deg;
    end
  end

  // row serializer
  logic                   o_v;
  lavm_pkg::row_t         beat;
  logic [2:0][DW-1:0]     o_t;
  logic [2:0][UW-1:0]     o_s, o_u, o_f;
  logic                   o_deg;

  assign adv = !o_v || (row.ready && (beat == lavm_pkg::ROW_H));

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v  <= 1'b0;
      beat <= lavm_pkg::ROW_S;
    end else if (adv) begin
      o_v  <= r3_v;
      beat <= lavm_pkg::ROW_S;
    end else if (row.ready) begin
      beat <= lavm_pkg::row_t'(beat + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_t   <= r3_t;
      o_s   <= r3_s;
      o_u   <= r3_u;
      o_f   <= r3_f;
      o_deg <= r3_deg;
    end
  end

  always_comb begin
    unique case (beat)
      lavm_pkg::ROW_S: begin
        row.col0 = {{(DW-UW){o_s[0][UW-1]}}, o_s[0]};
        row.col1 = {{(DW-UW){o_s[1][UW-1]}}, o_s[1]};
        row.col2 = {{(DW-UW){o_s[2][UW-1]}}, o_s[2]};
        row.col3 = o_t[0];
      end
      lavm_pkg::ROW_U: begin
        row.col0 = {{(DW-UW){o_u[0][UW-1]}}, o_u[0]};
        row.col1 = {{(DW-UW){o_u[1][UW-1]}}, o_u[1]};
        row.col2 = {{(DW-UW){o_u[2][UW-1]}}, o_u[2]};
        row.col3 = o_t[1];
      end
      lavm_pkg::ROW_F: begin
        row.col0 = ~{{(DW-UW){o_f[0][UW-1]}}, o_f[0]} + 1'b1;
        row.col1 = ~{{(DW-UW){o_f[1][UW-1]}}, o_f[1]} + 1'b1;
        row.col2 = ~{{(DW-UW){o_f[2][UW-1]}}, o_f[2]} + 1'b1;
        row.col3 = o_t[2];
      end
      lavm_pkg::ROW_H: begin
        row.col0 = '0;
        row.col1 = '0;
        row.col2 = '0;
        row.col3 = DW'(1) << FRAC_BITS;
      end
      default: begin
        row.col0 = '0;
        row.col1 = '0;
        row.col2 = '0;
        row.col3 = '0;
      end
    endcase
  end

  assign row.valid      = o_v;
  assign row.row_index  = beat;
  assign row.degenerate = o_deg;
  assign row.last_row   = (beat == lavm_pkg::ROW_H);

endmodule

// ----- src/look_at_view_matrix_unit.sv -----
// Look-at view matrix unit: builds a right-handed view matrix from eye, target and up.
//
// Requests arrive on req (valid/ready): eye, target and up hint, signed fixed point
// with FRAC_BITS fraction bits. Each accepted request yields four beats on row, in
// order: side, true up, negated forward, and the homogeneous row, the last one flagged
// by last_row. degenerate is set on all four beats when a normalized vector had zero
// length; that vector and the ones built from it read as zero.
// A request passes the input stage, the up and forward normalizers, a cross product
// and a normalizer for the side vector, another such pair for the true up vector and
// the row output stages. While a request is on the row port, the pipeline advances
// only when its last beat is taken; it takes a new request in any cycle it advances.
// The whole pipeline advances together; when the row receiver stalls, every stage
// holds and req.ready drops, so nothing is lost or repeated.
// Reset clears all valid bits; req.ready is high in the cycle after reset.
module look_at_view_matrix_unit #(
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lavm_req_if.sink   req,
  lavm_row_if.source row
);

  localparam int DW = lavm_pkg::DATA_W;
  localparam int UW = FRAC_BITS + 2;
  localparam int CW = 2 * UW + 1;
  localparam int NL = lavm_pkg::norm_lat(FRAC_BITS);

  logic adv;

  // input stage
  logic                                  t_valid;
  logic [2:0][DW-1:0]                    t_eye;
  logic [2:0][lavm_pkg::DIFF_W-1:0]      t_diff;
  logic [2:0][DW-1:0]                    t_up;

  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (adv) begin
      t_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_eye[0]  <= req.eye_x;
      t_eye[1]  <= req.eye_y;
      t_eye[2]  <= req.eye_z;
      t_diff[0] <= {req.target_x[DW-1], req.target_x} - {req.eye_x[DW-1], req.eye_x};
      t_diff[1] <= {req.target_y[DW-1], req.target_y} - {req.eye_y[DW-1], req.eye_y};
      t_diff[2] <= {req.target_z[DW-1], req.target_z} - {req.eye_z[DW-1], req.eye_z};
      t_up[0]   <= req.up_x;
      t_up[1]   <= req.up_y;
      t_up[2]   <= req.up_z;
    end
  end

  // up and forward normalizers
  logic [2:0][UW-1:0] nup, fv;
  logic               deg_up, deg_fw;

  lavm_norm #(.IW(DW), .FRAC_BITS(FRAC_BITS)) u_norm_up (
    .clk(clk), .adv(adv), .vec(t_up), .unit(nup), .deg(deg_up)
  );

  lavm_norm #(.IW(lavm_pkg::DIFF_W), .FRAC_BITS(FRAC_BITS)) u_norm_fw (
    .clk(clk), .adv(adv), .vec(t_diff), .unit(fv), .deg(deg_fw)
  );

  logic               v1;
  logic [2:0][DW-1:0] eye1;

  lavm_delay #(.W(3*DW), .DEPTH(NL)) u_dly1 (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(t_valid), .in_data(t_eye),
    .out_valid(v1), .out_data(eye1)
  );

  // side vector
  logic [2:0][CW-1:0] c1;
  logic [2:0][UW-1:0] sv;
  logic               deg_s;

  lavm_cross #(.FRAC_BITS(FRAC_BITS)) u_cross_s (
    .clk(clk), .adv(adv), .a(fv), .b(nup), .c(c1)
  );

  lavm_norm #(.IW(CW), .FRAC_BITS(FRAC_BITS)) u_norm_s (
    .clk(clk), .adv(adv), .vec(c1), .unit(sv), .deg(deg_s)
  );

  logic               v2;
  logic [2:0][DW-1:0] eye2;
  logic [2:0][UW-1:0] f2;
  logic               deg2;

  lavm_delay #(.W(3*DW + 3*UW + 1), .DEPTH(NL + 2)) u_dly2 (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(v1), .in_data({eye1, fv, deg_up | deg_fw}),
    .out_valid(v2), .out_data({eye2, f2, deg2})
  );

  // true up vector
  logic [2:0][CW-1:0] c2;
  logic [2:0][UW-1:0] uv;
  logic               deg_u;

  lavm_cross #(.FRAC_BITS(FRAC_BITS)) u_cross_u (
    .clk(clk), .adv(adv), .a(sv), .b(f2), .c(c2)
  );

  lavm_norm #(.IW(CW), .FRAC_BITS(FRAC_BITS)) u_norm_u (
    .clk(clk), .adv(adv), .vec(c2), .unit(uv), .deg(deg_u)
  );

  logic               v3;
  logic [2:0][DW-1:0] eye3;
  logic [2:0][UW-1:0] f3, s3;
  logic               deg3;

  lavm_delay #(.W(3*DW + 6*UW + 1), .DEPTH(NL + 2)) u_dly3 (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(v2), .in_data({eye2, f2, sv, deg2 | deg_s}),
    .out_valid(v3), .out_data({eye3, f3, s3, deg3})
  );

  lavm_rowout #(.FRAC_BITS(FRAC_BITS)) u_rowout (
    .clk(clk), .rst(rst), .in_valid(v3), .eye(eye3),
    .s(s3), .u(uv), .f(f3), .deg(deg3 | deg_u),
    .adv(adv), .row(row)
  );

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !row.valid |-> req.ready)
    else $error("request port stalled while no row is pending");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    row.valid && row.ready && (row.row_index != lavm_pkg::ROW_H)
    |=> row.valid && (row.row_index == $past(row.row_index) + 2'd1))
    else $error("row beats of a request out of order or dropped");

  a_deg_hold: assert property (@(posedge clk) disable iff (rst)
    row.valid && row.ready && (row.row_index != lavm_pkg::ROW_H)
    |=> $stable(row.degenerate))
    else $error("degenerate flag changed within one request");

endmodule

// ----- verif/tb_look_at_view_matrix_unit.sv -----
// Testbench for the look-at view matrix unit: directed and random requests, scoreboard with a row predictor.
module tb_look_at_view_matrix_unit;

  localparam int FRAC       = lavm_pkg::FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN      = 700;
  localparam int N_RANDOM   = 380;

  typedef logic signed [lavm_pkg::DATA_W-1:0] word_t;

  typedef struct {
    lavm_pkg::row_t idx;
    word_t          c0;
    word_t          c1;
    word_t          c2;
    word_t          c3;
    logic           degen;
    logic           last;
  } view_row_t;

  class view_matrix_board;
    view_row_t rows_due[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function bit [63:0] root64(bit [63:0] v);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function bit unit_vec(input longint v[3], output longint o[3]);
      bit [63:0] m[3];
      bit [63:0] mx;
      bit [63:0] sum;
      bit [63:0] len;
      bit [63:0] q;
      for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[0] == 0 && m[1] == 0 && m[2] == 0) begin
        for (int i = 0; i < 3; i++) o[i] = 0;
        return 1'b1;
      end
      forever begin
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx < (64'd1 << 31)) break;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = root64(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << FRAC) + (len >> 1)) / len;
        o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b0;
    endfunction

    function void cross_prod(input longint a[3], input longint b[3], output longint r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function word_t offset(input longint u[3], input longint p[3], input bit neg);
      longint    d;
      bit [63:0] mg;
      longint    r;
      d = u[0] * p[0] + u[1] * p[1] + u[2] * p[2];
      mg = ((d < 0 ? -d : d) + (64'd1 << (FRAC - 1))) >> FRAC;
      r = d < 0 ? -longint'(mg) : longint'(mg);
      if (neg) r = -r;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return word_t'(r);
    endfunction

    function void note(input longint in[9]);
      longint    eye[3], fwd[3], up[3], nup[3], f[3], s[3], u[3], c[3];
      bit        deg;
      view_row_t r;
      for (int i = 0; i < 3; i++) begin
        eye[i] = in[i];
        fwd[i] = in[3 + i] - in[i];
        up[i]  = in[6 + i];
      end
      deg = unit_vec(up, nup);
      deg |= unit_vec(fwd, f);
      cross_prod(f, nup, c);
      deg |= unit_vec(c, s);
      cross_prod(s, f, c);
      deg |= unit_vec(c, u);
      r.degen = deg;
      r.last = 1'b0;
      r.idx = lavm_pkg::ROW_S;
      r.c0 = word_t'(s[0]); r.c1 = word_t'(s[1]); r.c2 = word_t'(s[2]);
      r.c3 = offset(s, eye, 1'b1);
      rows_due.push_back(r);
      r.idx = lavm_pkg::ROW_U;
      r.c0 = word_t'(u[0]); r.c1 = word_t'(u[1]); r.c2 = word_t'(u[2]);
      r.c3 = offset(u, eye, 1'b1);
      rows_due.push_back(r);
      r.idx = lavm_pkg::ROW_F;
      r.c0 = word_t'(-f[0]); r.c1 = word_t'(-f[1]); r.c2 = word_t'(-f[2]);
      r.c3 = offset(f, eye, 1'b0);
      rows_due.push_back(r);
      r.idx = lavm_pkg::ROW_H;
      r.c0 = 0; r.c1 = 0; r.c2 = 0; r.c3 = word_t'(1) <<< FRAC;
      r.last = 1'b1;
      rows_due.push_back(r);
    endfunction

    function void check(input view_row_t got);
      view_row_t e;
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected row beat idx=%0d c0=%h c1=%h c2=%h c3=%h", $time,
                 got.idx, got.c0, got.c1, got.c2, got.c3);
        errors++;
        return;
      end
      e = rows_due.pop_front();
      if (got.idx !== e.idx) begin
        $display("%0t: row_index expected %0d actual %0d", $time, e.idx, got.idx);
        errors++;
      end
      if (got.c0 !== e.c0) begin
        $display("%0t: col0 expected %h actual %h", $time, e.c0, got.c0);
        errors++;
      end
      if (got.c1 !== e.c1) begin
        $display("%0t: col1 expected %h actual %h", $time, e.c1, got.c1);
        errors++;
      end
      if (got.c2 !== e.c2) begin
        $display("%0t: col2 expected %h actual %h", $time, e.c2, got.c2);
        errors++;
      end
      if (got.c3 !== e.c3) begin
        $display("%0t: col3 expected %h actual %h", $time, e.c3, got.c3);
        errors++;
      end
      if (got.degen !== e.degen) begin
        $display("%0t: degenerate expected %b actual %b", $time, e.degen, got.degen);
        errors++;
      end
      if (got.last !== e.last) begin
        $display("%0t: last_row expected %b actual %b", $time, e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  lavm_req_if req ();
  lavm_row_if row ();

  look_at_view_matrix_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .row (row.source)
  );

  always #1 clk = ~clk;

  view_matrix_board board = new();
  int  idle_cycles = 0;
  int  rx_mode = 0;
  int  rx_left = 0;

  // beat monitor: predict on accepted requests, check accepted rows
  always @(posedge clk) begin
    longint    a[9];
    view_row_t got;
    if (!rst) begin
      if (req.valid && req.ready) begin
        a[0] = longint'(req.eye_x); a[1] = longint'(req.eye_y);
        a[2] = longint'(req.eye_z);
        a[3] = longint'(req.target_x); a[4] = longint'(req.target_y);
        a[5] = longint'(req.target_z);
        a[6] = longint'(req.up_x); a[7] = longint'(req.up_y); a[8] = longint'(req.up_z);
        board.note(a);
      end
      if (row.valid && row.ready) begin
        got.idx = lavm_pkg::row_t'(row.row_index);
        got.c0 = row.col0; got.c1 = row.col1; got.c2 = row.col2; got.c3 = row.col3;
        got.degen = row.degenerate;
        got.last = row.last_row;
        board.check(got);
      end
      if ((req.valid && req.ready) || (row.valid && row.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall pattern, switching mode now and then
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(32, 256);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: row.ready <= 1'b1;
      1: row.ready <= $urandom_range(0, 1);
      2: row.ready <= ($urandom_range(0, 3) == 0);
      default: row.ready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  int burst_left = 0;

  task automatic send(input word_t v[9]);
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.eye_x <= v[0]; req.eye_y <= v[1]; req.eye_z <= v[2];
    req.target_x <= v[3]; req.target_y <= v[4]; req.target_z <= v[5];
    req.up_x <= v[6]; req.up_y <= v[7]; req.up_z <= v[8];
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic word_t near(input int r);
    return word_t'(int'($urandom_range(0, 2 * r)) - r);
  endfunction

  task automatic send_random();
    word_t v[9];
    int    kind;
    int    k;
    kind = $urandom_range(0, 19);
    for (int i = 0; i < 9; i++) v[i] = near(100 << FRAC);
    if (kind < 5) begin
      for (int i = 0; i < 9; i++) v[i] = $urandom;
    end else if (kind < 7) begin
      for (int i = 0; i < 9; i++) v[i] = near(8);
    end else if (kind == 7) begin
      k = int'($urandom_range(0, 6)) - 3;
      for (int i = 0; i < 3; i++) v[6 + i] = (v[3 + i] - v[i]) * k;
    end else if (kind == 8) begin
      for (int i = 0; i < 3; i++) v[3 + i] = v[i];
    end else if (kind == 9) begin
      for (int i = 0; i < 3; i++) v[6 + i] = 0;
    end else if (kind == 10) begin
      for (int i = 0; i < 9; i++) begin
        case ($urandom_range(0, 3))
          0: v[i] = lavm_pkg::DATA_MAX;
          1: v[i] = lavm_pkg::DATA_MIN;
          2: v[i] = 0;
          default: v[i] = $urandom;
        endcase
      end
    end
    send(v);
  endtask

  task automatic send_fixed(input word_t e0, e1, e2, t0, t1, t2, u0, u1, u2);
    word_t v[9];
    v[0] = e0; v[1] = e1; v[2] = e2;
    v[3] = t0; v[4] = t1; v[5] = t2;
    v[6] = u0; v[7] = u1; v[8] = u2;
    send(v);
  endtask

  initial begin
    word_t one;
    word_t dmax;
    word_t dmin;
    one = word_t'(1) <<< FRAC;
    dmax = lavm_pkg::DATA_MAX;
    dmin = lavm_pkg::DATA_MIN;
    req.valid <= 1'b0;
    req.eye_x <= '0; req.eye_y <= '0; req.eye_z <= '0;
    req.target_x <= '0; req.target_y <= '0; req.target_z <= '0;
    req.up_x <= '0; req.up_y <= '0; req.up_z <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_fixed(0, 0, 5 * one, 0, 0, 0, 0, one, 0);
    send_fixed(one, 2 * one, 3 * one, -one, 0, one, 0, 0, one);
    send_fixed(0, 0, 0, 0, 0, 0, 0, one, 0);
    send_fixed(one, one, one, one, one, one, 0, one, 0);
    send_fixed(0, 0, one, 0, 0, 0, 0, 0, 0);
    send_fixed(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_fixed(0, 0, 0, 0, 5 * one, 0, 0, one, 0);
    send_fixed(0, 0, 0, 0, 5 * one, 0, 0, -3 * one, 0);
    send_fixed(0, 0, 0, 0, 1, 0, 1, 0, 0);
    send_fixed(dmax, dmax, dmax, dmin, dmin, dmin, dmax, dmin, dmax);
    send_fixed(dmin, dmin, dmin, dmax, dmax, dmax, dmin, dmin, dmin);
    send_fixed(dmax, dmin, 0, 0, dmax, dmin, dmin, 0, dmax);
    send_fixed(dmax, 0, 0, dmin, one, 0, 0, dmax, 0);
    send_fixed(-1, -1, -1, 1, 1, 1, -1, 1, -1);
    send_fixed(0, 0, 0, 1, 0, 0, 0, 1, 0);
    send_fixed(0, 0, 0, 0, 0, 0, dmin, dmin, dmin);
    send_fixed(3 * one, -7 * one, one / 2, -one, 4 * one, 9 * one, one, one, 0);
    send_fixed(dmax, dmax, dmax, 0, 0, 0, 0, one, 0);
    send_fixed(0, 0, 0, one, 1, 0, one, 0, 0);
    send_fixed(-32'sh7fff_0000, 32'sh7fff_0000, 0, 32'sh7fff_0000, -32'sh7fff_0000, 0,
               0, 0, one);
    for (int n = 0; n < N_RANDOM; n++) send_random();
    req.valid <= 1'b0;
    while (board.rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
